// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl of the coverage bitmap marker
// depends on nothing; the clock and reset names are passed in or taken from the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic concurrent check with explicit clock and active-low reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on the block clock clk_i and reset rst_ni
`define ASSERT_CLK(label, prop, msg) \
  `ASSERT_IMPL(label, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/cbm_pkg.sv -----
// package of the coverage bitmap marker: widths, action codes, fsm states
// and the command/status structs between controller and datapath; no dependencies
`default_nettype none

package cbm_pkg;

  localparam int ADDR_W          = 48;
  localparam int OPD_W           = 32;
  localparam int TOTAL_W         = 32;
  localparam int MARKS_W         = 3;
  localparam int WORD_W          = 64;
  localparam int BIT_IDX_W       = 6;
  localparam int WINDOW_BITS_DEF = 20;
  localparam int S_TDATA_W       = 120;
  localparam int S_TUSER_W       = 2;
  localparam int M_TDATA_W       = 40;

  typedef enum logic [1:0] {
    ACT_INSTR  = 2'd0,
    ACT_CMP    = 2'd1,
    ACT_BRANCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_CLEAR,
    ST_DONE
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic rd;     // compute window offset and read the bitmap word
    logic wr;     // test-and-set the bit, step to the next address
    logic sweep;  // zero one bitmap word of the clearing pass
    logic fin;    // move the result into the output register
  } cbm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_clear;    // incoming item is a clear
    logic in_none;     // incoming item marks no address
    logic rem_last;    // the address under test is the last one
    logic sweep_last;  // clearing pass is at the last word
    logic out_free;    // output register can take a result
  } cbm_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cbm_ram.sv -----
// single-port-write, single-port-read bitmap memory with registered read data
// depends on nothing
`default_nettype none

module cbm_ram #(
  parameter int AW = 14,
  parameter int DW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cbm_ctrl.sv -----
// controller of the coverage bitmap marker: sequences init sweep, per-address
// read/test steps, clear sweep and result hand-off; depends on cbm_pkg
`default_nettype none

module cbm_ctrl import cbm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire cbm_sts_t sts_i,
  output cbm_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (sts_i.in_clear) begin
            state_d = ST_CLEAR;
          end else if (sts_i.in_none) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_TEST;
      end
      ST_TEST: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.rem_last ? ST_DONE : ST_READ;
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cbm_dp.sv -----
// datapath of the coverage bitmap marker: item registers, window offset,
// bitmap memory, test-and-set, running total and output register; depends on cbm_pkg, cbm_ram
`default_nettype none

module cbm_dp import cbm_pkg::*; #(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cbm_cmd_t           cmd_i,
  output cbm_sts_t                sts_o,
  input  wire logic               cfg_we_i,
  input  wire logic [ADDR_W-1:0]  cfg_wdata_i,
  input  wire action_e            in_action_i,
  input  wire logic [ADDR_W-1:0]  in_address_i,
  input  wire logic [OPD_W-1:0]   in_left_i,
  input  wire logic [OPD_W-1:0]   in_right_i,
  input  wire logic               in_taken_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [MARKS_W-1:0]      out_marks_o,
  output logic [TOTAL_W-1:0]      out_total_o,
  output logic                    out_outside_o
);

  localparam int IDX_W = WINDOW_BITS - BIT_IDX_W;

  logic [ADDR_W-1:0]    base_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [IDX_W-1:0]     sweep_q;
  logic                 out_valid_q;
  action_e              action_q;
  logic [ADDR_W-1:0]    cur_addr_q;
  logic [MARKS_W-1:0]   rem_q;
  logic [MARKS_W-1:0]   marks_q;
  logic                 outside_q;
  logic                 inside_q;
  logic [IDX_W-1:0]     word_idx_q;
  logic [BIT_IDX_W-1:0] bit_idx_q;
  logic [MARKS_W-1:0]   out_marks_q;
  logic [TOTAL_W-1:0]   out_total_q;
  logic                 out_outside_q;

  logic [3:0]           byte_eq;
  logic [MARKS_W-1:0]   eq_cnt;
  logic [MARKS_W-1:0]   rem_d;
  logic [1:0]           first_step;
  logic [ADDR_W-1:0]    off;
  logic                 off_inside;
  logic [WORD_W-1:0]    rdata;
  logic [WORD_W-1:0]    bit_mask;
  logic                 newly;
  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   total_sat;
  logic                 counts_total;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  // equal byte lanes of the compare operands
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      byte_eq[i] = (in_left_i[8*i +: 8] == in_right_i[8*i +: 8]);
    end
    eq_cnt = MARKS_W'(byte_eq[0]) + MARKS_W'(byte_eq[1])
           + MARKS_W'(byte_eq[2]) + MARKS_W'(byte_eq[3]);
  end

  // address count and first address offset per action
  always_comb begin
    unique case (in_action_i)
      ACT_INSTR: begin
        rem_d      = MARKS_W'(1);
        first_step = 2'd0;
      end
      ACT_CMP: begin
        rem_d      = eq_cnt;
        first_step = 2'd1;
      end
      ACT_BRANCH: begin
        rem_d      = MARKS_W'(1);
        first_step = in_taken_i ? 2'd1 : 2'd2;
      end
      ACT_CLEAR: begin
        rem_d      = '0;
        first_step = 2'd0;
      end
      default: begin
        rem_d      = '0;
        first_step = 2'd0;
      end
    endcase
  end

  // window offset of the current address
  assign off        = cur_addr_q - base_q;
  assign off_inside = (off[ADDR_W-1:WINDOW_BITS] == '0);

  // test-and-set on the word read back
  assign bit_mask = WORD_W'(1) << bit_idx_q;
  assign newly    = inside_q && !rdata[bit_idx_q];

  // saturating running total
  assign sum          = {1'b0, total_q} + (TOTAL_W + 1)'(marks_q);
  assign total_sat    = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign counts_total = (action_q == ACT_CMP) || (action_q == ACT_BRANCH);

  // memory write port: clearing pass or test-and-set
  always_comb begin
    if (cmd_i.sweep) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd_i.wr && newly;
      mem_waddr = word_idx_q;
      mem_wdata = rdata | bit_mask;
    end
  end

  cbm_ram #(
    .AW (IDX_W),
    .DW (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (off[WINDOW_BITS-1:BIT_IDX_W]),
    .rdata_o (rdata)
  );

  // control registers: window base, total, sweep counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      total_q     <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.sweep) begin
        sweep_q <= sweep_q + IDX_W'(1);
      end
      if (cmd_i.fin && counts_total) begin
        total_q <= total_sat;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item registers and per-address stepping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q   <= in_action_i;
      cur_addr_q <= in_address_i + ADDR_W'(first_step);
      rem_q      <= rem_d;
      marks_q    <= '0;
      outside_q  <= 1'b0;
    end
    if (cmd_i.rd) begin
      inside_q   <= off_inside;
      word_idx_q <= off[WINDOW_BITS-1:BIT_IDX_W];
      bit_idx_q  <= off[BIT_IDX_W-1:0];
    end
    if (cmd_i.wr) begin
      marks_q    <= marks_q + MARKS_W'(newly);
      outside_q  <= outside_q || !inside_q;
      cur_addr_q <= cur_addr_q + ADDR_W'(1);
      rem_q      <= rem_q - MARKS_W'(1);
    end
    if (cmd_i.fin) begin
      out_marks_q   <= marks_q;
      out_outside_q <= outside_q;
      out_total_q   <= counts_total ? total_sat : total_q;
    end
  end

  // status to the controller
  assign sts_o.in_clear   = (in_action_i == ACT_CLEAR);
  assign sts_o.in_none    = (rem_d == '0);
  assign sts_o.rem_last   = (rem_q == MARKS_W'(1));
  assign sts_o.sweep_last = &sweep_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_marks_o   = out_marks_q;
  assign out_total_o   = out_total_q;
  assign out_outside_o = out_outside_q;

endmodule

`default_nettype wire

// ----- hw/rtl/coverage_bitmap_marker.sv -----
// top level of the coverage bitmap marker: stream ports, controller and datapath
// depends on cbm_pkg, cbm_ctrl, cbm_dp, cbm_ram and assert_macros.svh
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: address, operands, taken; tuser: action
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: new_marks, running_total, outside
// cfg       in         cfg_we_i                     cfg_wdata_i: window_base
//
// each address to mark takes a bitmap read step and a test-and-set step on the one
// memory; an item is taken in ST_IDLE, marks its addresses (one for instruction and
// branch, zero to four for compare) and finishes in ST_DONE. a clear walks the memory
// one word a cycle; after reset the same walk runs before the first item is taken.
// a result waits in the output register while the next item is accepted; a second
// finished result holds until that register drains.
`default_nettype none
`include "assert_macros.svh"

module coverage_bitmap_marker import cbm_pkg::*; #(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration: window_base
  input  wire logic                 cfg_we_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i,
  // input items
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // address [47:0], left_operand [79:48], right_operand [111:80], branch_taken [112]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // action [1:0]
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
  // result items
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // new_marks [2:0], running_total [34:3], outside_window [35]
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  cbm_cmd_t           cmd;
  cbm_sts_t           sts;
  logic [MARKS_W-1:0] out_marks;
  logic [TOTAL_W-1:0] out_total;
  logic               out_outside;

  cbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbm_dp #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_action_i   (action_e'(s_axis_tuser[1:0])),
    .in_address_i  (s_axis_tdata[47:0]),
    .in_left_i     (s_axis_tdata[79:48]),
    .in_right_i    (s_axis_tdata[111:80]),
    .in_taken_i    (s_axis_tdata[112]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_marks_o   (out_marks),
    .out_total_o   (out_total),
    .out_outside_o (out_outside)
  );

  // result packing, zero padded to whole bytes
  assign m_axis_tdata = {4'b0, out_outside, out_total, out_marks};

  // checks
  `ASSERT_CLK(a_marks_range, m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd4), "new_marks above four")
  `ASSERT_CLK(a_read_then_test, cmd.rd |=> cmd.wr, "bitmap read not followed by test-and-set")
  `ASSERT_CLK(a_fin_shows, cmd.fin |=> m_axis_tvalid, "finished item not presented")
  `ASSERT_CLK(a_no_accept_in_sweep, cmd.sweep |-> !s_axis_tready, "item taken during clearing")

endmodule

`default_nettype wire

// ----- tb/cbm_marks_checker.sv -----
`timescale 1ns / 1ps
// checker for the coverage bitmap marker: watches config, input and result channels,
// keeps its own copy of the bitmap and running total and compares every result item
// depends on cbm_pkg only

module cbm_marks_checker import cbm_pkg::*; #(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // address [47:0], left_operand [79:48], right_operand [111:80], branch_taken [112]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // action [1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // new_marks [2:0], running_total [34:3], outside_window [35]
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam int NUM_WORDS = 1 << (WINDOW_BITS - BIT_IDX_W);

  typedef struct packed {
    logic               outside;
    logic [TOTAL_W-1:0] total;
    logic [MARKS_W-1:0] marks;
  } mark_report_t;

  bit [WORD_W-1:0]    cov_words [NUM_WORDS];
  logic [TOTAL_W-1:0] running_total;
  logic [ADDR_W-1:0]  win_base;
  mark_report_t       mark_reports [$];
  mark_report_t       got;
  mark_report_t       want;
  int                 mismatches;

  function automatic void clear_bitmap();
    for (int w = 0; w < NUM_WORDS; w++) cov_words[w] = '0;
  endfunction

  // test-and-set one address, returns {outside, newly set}
  function automatic logic [1:0] test_and_set(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    off = addr - win_base;
    if ((off >> WINDOW_BITS) != 0) return 2'b10;
    if (cov_words[off[WINDOW_BITS-1:BIT_IDX_W]][off[BIT_IDX_W-1:0]]) return 2'b00;
    cov_words[off[WINDOW_BITS-1:BIT_IDX_W]][off[BIT_IDX_W-1:0]] = 1'b1;
    return 2'b01;
  endfunction

  // work out the result of one event and update the bitmap and running total
  function automatic mark_report_t apply_event(input action_e act,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [OPD_W-1:0] lhs,
                                               input logic [OPD_W-1:0] rhs,
                                               input logic taken);
    mark_report_t res;
    logic [1:0]   r;
    logic [TOTAL_W:0] sum;
    int           equal;
    res = '0;
    equal = 0;
    case (act)
      ACT_INSTR: begin
        r = test_and_set(addr);
        res.marks = MARKS_W'(r[0]);
        res.outside = r[1];
      end
      ACT_CMP, ACT_BRANCH: begin
        if (act == ACT_CMP) begin
          for (int i = 0; i < 4; i++) if (lhs[8*i +: 8] == rhs[8*i +: 8]) equal++;
          for (int i = 0; i < equal; i++) begin
            r = test_and_set(addr + ADDR_W'(1 + i));
            res.marks = res.marks + MARKS_W'(r[0]);
            res.outside = res.outside | r[1];
          end
        end else begin
          r = test_and_set(addr + (taken ? ADDR_W'(1) : ADDR_W'(2)));
          res.marks = MARKS_W'(r[0]);
          res.outside = r[1];
        end
        // saturating running total
        sum = {1'b0, running_total} + (TOTAL_W + 1)'(res.marks);
        running_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      end
      default: clear_bitmap();
    endcase
    res.total = running_total;
    return res;
  endfunction

  // watch the channels, predict on input items, compare on result items
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_bitmap();
      running_total = '0;
      win_base = '0;
      mark_reports.delete();
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) win_base = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.marks = m_axis_tdata[2:0];
        got.total = m_axis_tdata[34:3];
        got.outside = m_axis_tdata[35];
        if (mark_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with none outstanding: marks %0d total %0h outside %0b",
                     $realtime, got.marks, got.total, got.outside);
        end else begin
          want = mark_reports.pop_front();
          if (got.marks !== want.marks || got.total !== want.total ||
              got.outside !== want.outside) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected marks %0d total %0h outside %0b,",
                       $realtime, want.marks, want.total, want.outside,
                       " got marks %0d total %0h outside %0b",
                       got.marks, got.total, got.outside);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        mark_reports.push_back(apply_event(action_e'(s_axis_tuser), s_axis_tdata[47:0],
                                           s_axis_tdata[79:48], s_axis_tdata[111:80],
                                           s_axis_tdata[112]));
      pending_o <= mark_reports.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/tb_coverage_bitmap_marker.sv -----
`timescale 1ns / 1ps
// top of the coverage bitmap marker testbench: clock, reset, stimulus and verdict
// depends on cbm_pkg, coverage_bitmap_marker and cbm_marks_checker

module tb_coverage_bitmap_marker;
  import cbm_pkg::*;

  localparam int          WINDOW_BITS = WINDOW_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          PHASE_ITEMS = 530;
  localparam logic [ADDR_W-1:0] WIN_SIZE = ADDR_W'(1) << WINDOW_BITS;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [ADDR_W-1:0]    cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  int                   pending;
  int                   fail_count;
  int                   src_idle_pct = 27;
  int                   dst_idle_pct = 64;
  int                   clears_sent = 0;
  int unsigned          cycles = 0;
  logic [ADDR_W-1:0]    cur_base = '0;

  coverage_bitmap_marker #(.WINDOW_BITS(WINDOW_BITS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cbm_marks_checker #(.WINDOW_BITS(WINDOW_BITS)) marks_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_coverage_bitmap_marker failed");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // present one item and hold it until taken
  task automatic send_item(input action_e act, input logic [ADDR_W-1:0] addr,
                           input logic [OPD_W-1:0] lhs, input logic [OPD_W-1:0] rhs,
                           input logic taken);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, taken, rhs, lhs, addr};
    s_axis_tuser <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait until every result item is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] base);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= base;
    cur_base = base;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ADDR_W-1:0];
  endfunction

  // addresses mostly near the window so marks repeat and edges get hit
  function automatic logic [ADDR_W-1:0] pick_address();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return cur_base + ADDR_W'($urandom_range(0, 191));
    if (sel < 55) return cur_base + WIN_SIZE - ADDR_W'($urandom_range(1, 6));
    if (sel < 63) return cur_base - ADDR_W'($urandom_range(1, 4));
    if (sel < 70) return ADDR_TOP - ADDR_W'($urandom_range(0, 4));
    if (sel < 80) return cur_base + (ADDR_W'($urandom()) & (WIN_SIZE - 1));
    return rand_addr48();
  endfunction

  task automatic run_random(input int count);
    action_e          act;
    logic [OPD_W-1:0] lhs;
    logic [OPD_W-1:0] rhs;
    for (int i = 0; i < count; i++) begin
      // pause now and then until all results are back
      if (i == count / 4 || $urandom_range(0, 199) == 0) drain();
      lhs = $urandom();
      rhs = lhs;
      if ($urandom_range(0, 99) < 15) begin
        rhs = $urandom();
      end else begin
        for (int b = 0; b < 4; b++)
          if ($urandom_range(0, 1)) rhs[8*b +: 8] = 8'($urandom_range(0, 255));
      end
      // clears walk the whole bitmap, keep them rare
      if ($urandom_range(0, 999) < 15 && clears_sent < 30) begin
        act = ACT_CLEAR;
        clears_sent++;
      end else begin
        case ($urandom_range(0, 2))
          0: act = ACT_INSTR;
          1: act = ACT_CMP;
          default: act = ACT_BRANCH;
        endcase
      end
      send_item(act, pick_address(), lhs, rhs, 1'($urandom_range(0, 1)));
    end
  endtask

  // stimulus
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_base('0);

    // directed: window at zero
    send_item(ACT_INSTR, '0, '0, '0, 1'b0);
    send_item(ACT_INSTR, '0, '0, '0, 1'b0);
    send_item(ACT_INSTR, WIN_SIZE - 1, '0, '0, 1'b0);
    send_item(ACT_INSTR, WIN_SIZE, '0, '0, 1'b0);
    send_item(ACT_INSTR, ADDR_TOP, '0, '0, 1'b0);
    send_item(ACT_CMP, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(ACT_CMP, '0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    // compare marking across the top edge of the window
    send_item(ACT_CMP, WIN_SIZE - 3, '0, '0, 1'b0);
    // compare addresses wrapping past the 48-bit top
    send_item(ACT_CMP, ADDR_TOP, 32'h1234_5678, 32'h1234_5600, 1'b0);
    send_item(ACT_CMP, ADDR_TOP - 1, 32'h1234_5678, 32'h1234_0000, 1'b0);
    send_item(ACT_BRANCH, 48'd10, '0, '0, 1'b1);
    send_item(ACT_BRANCH, 48'd10, '0, '0, 1'b0);
    send_item(ACT_BRANCH, 48'd10, '0, '0, 1'b1);
    send_item(ACT_BRANCH, ADDR_TOP, '0, '0, 1'b0);
    send_item(ACT_BRANCH, ADDR_TOP, '0, '0, 1'b1);
    send_item(ACT_BRANCH, WIN_SIZE - 1, '0, '0, 1'b1);
    send_item(ACT_CLEAR, ADDR_TOP, '1, '1, 1'b1);
    send_item(ACT_INSTR, '0, '1, '0, 1'b1);
    send_item(ACT_BRANCH, ADDR_TOP - 1, '0, '0, 1'b1);
    send_item(ACT_CMP, 48'd100, 32'hA5A5_A5A5, 32'h5A5A_5AA5, 1'b1);
    clears_sent = 1;

    // directed: window wrapping past the top of the address space
    drain();
    write_base(ADDR_TOP - 15);
    send_item(ACT_INSTR, ADDR_TOP - 15, '0, '0, 1'b0);
    send_item(ACT_INSTR, 48'd5, '0, '0, 1'b0);
    send_item(ACT_INSTR, ADDR_TOP - 16, '0, '0, 1'b0);
    send_item(ACT_CMP, ADDR_TOP - 1, 32'hCAFE_F00D, 32'hCAFE_F00D, 1'b0);

    // random phases: sender mostly busy, then receiver mostly busy, then no idling
    drain();
    write_base(rand_addr48());
    src_idle_pct = 27;
    dst_idle_pct = 64;
    run_random(PHASE_ITEMS);

    drain();
    write_base(ADDR_TOP);
    src_idle_pct = 64;
    dst_idle_pct = 27;
    run_random(PHASE_ITEMS);

    drain();
    write_base(ADDR_TOP - (WIN_SIZE >> 1) + 1);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_coverage_bitmap_marker passed");
    end else begin
      $display("tb_coverage_bitmap_marker failed");
    end
    $finish;
  end

endmodule
